[hw/rtl/ecost_pkg.sv]
// Shared widths, request codes and limits for the edge contraction cost block.
// Used by the channel interfaces and by the top level module of the block.
`timescale 1ns / 1ps

package ecost_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = VIDX_W + 1;
    localparam int ADDR_W       = 2 * VIDX_W;
    localparam int MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
    localparam int WGT_W        = 32;
    localparam int IN_WGT_W     = 16;
    localparam int COST_W       = 63;
    localparam int REQ_W        = 2;

    typedef logic [REQ_W-1:0] req_type_t;

    localparam req_type_t REQ_RESET    = 2'd0;
    localparam req_type_t REQ_SET      = 2'd1;
    localparam req_type_t REQ_CONTRACT = 2'd2;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = VCNT_W'(MAX_VERTICES);
    localparam logic [COST_W-1:0] COST_LIMIT   = {COST_W{1'b1}};
    localparam logic [WGT_W-1:0]  WGT_LIMIT    = {WGT_W{1'b1}};

endpackage

[hw/rtl/ecost_req_if.sv]
// Request channel: valid/ready handshake with the request payload.
// Depends on ecost_pkg for field widths.
`timescale 1ns / 1ps

interface ecost_req_if;
    logic                               valid;
    logic                               ready;
    ecost_pkg::req_type_t               req_type;
    logic [ecost_pkg::VIDX_W-1:0]       vertex_a;
    logic [ecost_pkg::VIDX_W-1:0]       vertex_b;
    logic [ecost_pkg::IN_WGT_W-1:0]     weight;

    modport source (output valid, req_type, vertex_a, vertex_b, weight, input ready);
    modport sink   (input valid, req_type, vertex_a, vertex_b, weight, output ready);
endinterface

[hw/rtl/ecost_rsp_if.sv]
// Result channel: valid/ready handshake with the result payload.
// Depends on ecost_pkg for field widths.
`timescale 1ns / 1ps

interface ecost_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ecost_pkg::COST_W-1:0]   step_cost;
    logic [ecost_pkg::COST_W-1:0]   total_cost;
    logic                           merged;
    logic [ecost_pkg::VIDX_W-1:0]   surviving_root;
    logic                           saturated;

    modport source (output valid, step_cost, total_cost, merged, surviving_root, saturated,
                    input ready);
    modport sink   (input valid, step_cost, total_cost, merged, surviving_root, saturated,
                    output ready);
endinterface

[hw/rtl/ecost_cfg_if.sv]
// Configuration write channel carrying the vertex count register.
// Depends on ecost_pkg for the register width.
`timescale 1ns / 1ps

interface ecost_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ecost_pkg::VCNT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/ecost_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ecost_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/edge_contraction_cost.sv]
// Top level of the edge contraction cost block: sequencer, link table and bond matrix.
// Depends on ecost_pkg, the three channel interfaces and ecost_ram.
`timescale 1ns / 1ps

// The req channel takes one request per transfer: reset network, set bond weight or
// contract edge. Every request yields exactly one transfer on the rsp channel with the
// step cost, the running total, the merge flag, the surviving root and a saturation flag.
// The cfg channel writes the vertex count; it is always ready. It is to be written while
// idle; the user is bound to this and the block itself does not enforce it.
// Requests are handled one at a time by a sequencer around one shared 32 x 32 multiplier
// and the bond matrix RAM with one write and one read port. A reset request, or one that
// changes nothing, goes straight to the finish state; a set weight request first writes
// both mirrored entries. A contraction walks both roots, checks them and reads their bond,
// then forms the cost products column by column (each 63 x 32 product runs as a select,
// two 32 x 32 halves and a combine), merges row b into row a and clears row b.
// After rst_n the matrix reads as ones with a zero diagonal through per entry valid bits,
// every vertex is a root, the total is zero and the vertex count is 16; no clearing pass.
// A finished result waits in the output register while the receiver stalls; a new request
// may be taken then, but its result waits until the previous one is transferred.
module edge_contraction_cost (
    input  logic               clk,
    input  logic               rst_n,
    ecost_cfg_if.sink          cfg,
    ecost_req_if.sink          req,
    ecost_rsp_if.source        rsp
);

    localparam int VW = ecost_pkg::VIDX_W;
    localparam int NW = ecost_pkg::VCNT_W;
    localparam int AW = ecost_pkg::ADDR_W;
    localparam int WW = ecost_pkg::WGT_W;
    localparam int CW = ecost_pkg::COST_W;
    localparam int NV = ecost_pkg::MAX_VERTICES;
    localparam int MD = ecost_pkg::MAT_DEPTH;

    typedef enum logic [4:0] {
        S_IDLE, S_WR1, S_WR2, S_WALK_A, S_WALK_B, S_CHECK, S_CINIT, S_CSEL, S_CMUL_L,
        S_CMUL_H, S_CACC, S_MSEL, S_MRA, S_MRB, S_MSAT, S_MW1, S_MW2, S_ZSEL, S_ZW2,
        S_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [NW-1:0]          vcount_reg, vcount_next;
    logic [NW-1:0]          n_reg, n_next;
    logic [VW-1:0]          va_reg, va_next;
    logic [VW-1:0]          vb_reg, vb_next;
    logic [ecost_pkg::IN_WGT_W-1:0] w_reg, w_next;
    logic [VW-1:0]          links_reg [NV];
    logic [VW-1:0]          links_next [NV];
    logic [MD-1:0]          valid_reg, valid_next;
    logic [VW-1:0]          walk_v_reg, walk_v_next;
    logic [VW-1:0]          walk_k_reg, walk_k_next;
    logic [VW-1:0]          root_a_reg, root_a_next;
    logic [VW-1:0]          root_b_reg, root_b_next;
    logic [NW-1:0]          j_reg, j_next;
    logic                   ph_reg, ph_next;
    logic [CW-1:0]          cost_reg, cost_next;
    logic [CW-1:0]          sum_reg, sum_next;
    logic                   sat_reg, sat_next;
    logic                   merged_reg, merged_next;
    logic [VW-1:0]          root_reg, root_next;
    logic [WW-1:0]          f_reg, f_next;
    logic [WW-1:0]          rowa_reg, rowa_next;
    logic [WW-1:0]          p_reg, p_next;
    logic [2*WW-1:0]        prod_lo_reg, prod_lo_next;
    logic [2*WW-1:0]        prod_hi_reg, prod_hi_next;
    logic [AW-1:0]          rd_addr_reg;
    logic                   rd_valid_reg;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]          out_step_reg, out_step_next;
    logic [CW-1:0]          out_total_reg, out_total_next;
    logic                   out_merged_reg, out_merged_next;
    logic [VW-1:0]          out_root_reg, out_root_next;
    logic                   out_sat_reg, out_sat_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WW-1:0]          ram_rdata;
    logic [WW-1:0]          eff_rdata;
    logic [WW-1:0]          mul_x, mul_y;
    logic [2*WW-1:0]        mul_p;
    logic [3*WW-1:0]        full_prod;
    logic [VW-1:0]          walk_p;
    logic [NW-1:0]          vcount_eff;
    logic                   req_fire;
    logic                   rsp_free;

    ecost_ram #(
        .WIDTH (WW),
        .DEPTH (MD)
    ) u_bond_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.step_cost      = out_step_reg;
    assign rsp.total_cost     = out_total_reg;
    assign rsp.merged         = out_merged_reg;
    assign rsp.surviving_root = out_root_reg;
    assign rsp.saturated      = out_sat_reg;

    // An entry never written since reset reads as one off the diagonal and zero on it.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            eff_rdata = ram_rdata;
        end
        else if (rd_addr_reg[AW-1:VW] == rd_addr_reg[VW-1:0])
        begin
            eff_rdata = '0;
        end
        else
        begin
            eff_rdata = WW'(1);
        end
    end

    assign mul_p     = mul_x * mul_y;
    assign full_prod = {prod_hi_reg, {WW{1'b0}}} + {{WW{1'b0}}, prod_lo_reg};
    assign walk_p    = links_reg[walk_v_reg];

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            vcount_eff = NW'(1);
        end
        else if (vcount_reg > NW'(NV))
        begin
            vcount_eff = NW'(NV);
        end
        else
        begin
            vcount_eff = vcount_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        vcount_next     = vcount_reg;
        n_next          = n_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        w_next          = w_reg;
        links_next      = links_reg;
        valid_next      = valid_reg;
        walk_v_next     = walk_v_reg;
        walk_k_next     = walk_k_reg;
        root_a_next     = root_a_reg;
        root_b_next     = root_b_reg;
        j_next          = j_reg;
        ph_next         = ph_reg;
        cost_next       = cost_reg;
        sum_next        = sum_reg;
        sat_next        = sat_reg;
        merged_next     = merged_reg;
        root_next       = root_reg;
        f_next          = f_reg;
        rowa_next       = rowa_reg;
        p_next          = p_reg;
        prod_lo_next    = prod_lo_reg;
        prod_hi_next    = prod_hi_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_step_next   = out_step_reg;
        out_total_next  = out_total_reg;
        out_merged_next = out_merged_reg;
        out_root_next   = out_root_reg;
        out_sat_next    = out_sat_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        mul_x           = '0;
        mul_y           = '0;

        if (cfg.valid)
        begin
            vcount_next = cfg.data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    va_next     = req.vertex_a;
                    vb_next     = req.vertex_b;
                    w_next      = req.weight;
                    n_next      = vcount_eff;
                    cost_next   = '0;
                    sat_next    = 1'b0;
                    merged_next = 1'b0;
                    root_next   = '0;
                    state_next  = S_FINISH;
                    if (req.req_type == ecost_pkg::REQ_RESET)
                    begin
                        valid_next = '0;
                        for (int i = 0; i < NV; i++)
                        begin
                            links_next[i] = VW'(i);
                        end
                        sum_next = '0;
                    end
                    else if (req.req_type == ecost_pkg::REQ_SET)
                    begin
                        if ({1'b0, req.vertex_a} < vcount_eff
                            && {1'b0, req.vertex_b} < vcount_eff
                            && req.vertex_a != req.vertex_b)
                        begin
                            state_next = S_WR1;
                        end
                    end
                    else if (req.req_type == ecost_pkg::REQ_CONTRACT)
                    begin
                        if ({1'b0, req.vertex_a} < vcount_eff
                            && {1'b0, req.vertex_b} < vcount_eff)
                        begin
                            walk_v_next = req.vertex_a;
                            walk_k_next = '0;
                            state_next  = S_WALK_A;
                        end
                    end
                end
            end

            S_WR1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {va_reg, vb_reg};
                ram_wdata  = WW'(w_reg);
                valid_next[{va_reg, vb_reg}] = 1'b1;
                state_next = S_WR2;
            end

            S_WR2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {vb_reg, va_reg};
                ram_wdata  = WW'(w_reg);
                valid_next[{vb_reg, va_reg}] = 1'b1;
                state_next = S_FINISH;
            end

            S_WALK_A:
            begin
                if (walk_p == walk_v_reg)
                begin
                    root_a_next = walk_v_reg;
                    walk_v_next = vb_reg;
                    walk_k_next = '0;
                    state_next  = S_WALK_B;
                end
                else if (walk_k_reg == VW'(NV - 1))
                begin
                    root_a_next = walk_p;
                    walk_v_next = vb_reg;
                    walk_k_next = '0;
                    state_next  = S_WALK_B;
                end
                else
                begin
                    walk_v_next = walk_p;
                    walk_k_next = walk_k_reg + VW'(1);
                end
            end

            S_WALK_B:
            begin
                if (walk_p == walk_v_reg)
                begin
                    root_b_next = walk_v_reg;
                    state_next  = S_CHECK;
                end
                else if (walk_k_reg == VW'(NV - 1))
                begin
                    root_b_next = walk_p;
                    state_next  = S_CHECK;
                end
                else
                begin
                    walk_v_next = walk_p;
                    walk_k_next = walk_k_reg + VW'(1);
                end
            end

            S_CHECK:
            begin
                state_next = S_FINISH;
                if ({1'b0, root_a_reg} < n_reg && {1'b0, root_b_reg} < n_reg)
                begin
                    root_next = root_a_reg;
                    if (root_a_reg != root_b_reg)
                    begin
                        ram_raddr  = {root_a_reg, root_b_reg};
                        state_next = S_CINIT;
                    end
                end
            end

            S_CINIT:
            begin
                cost_next  = CW'(eff_rdata);
                j_next     = '0;
                ph_next    = 1'b0;
                state_next = S_CSEL;
            end

            // The first term of each column comes from row b, the second from row a.
            S_CSEL:
            begin
                if (j_reg == n_reg)
                begin
                    j_next     = '0;
                    state_next = S_MSEL;
                end
                else if (!ph_reg)
                begin
                    if (j_reg[VW-1:0] != root_a_reg)
                    begin
                        ram_raddr  = {root_b_reg, j_reg[VW-1:0]};
                        state_next = S_CMUL_L;
                    end
                    else
                    begin
                        ph_next = 1'b1;
                    end
                end
                else
                begin
                    if (j_reg[VW-1:0] != root_b_reg)
                    begin
                        ram_raddr  = {root_a_reg, j_reg[VW-1:0]};
                        state_next = S_CMUL_L;
                    end
                    else
                    begin
                        ph_next = 1'b0;
                        j_next  = j_reg + NW'(1);
                    end
                end
            end

            S_CMUL_L:
            begin
                f_next       = (eff_rdata == '0) ? WW'(1) : eff_rdata;
                mul_x        = cost_reg[WW-1:0];
                mul_y        = (eff_rdata == '0) ? WW'(1) : eff_rdata;
                prod_lo_next = mul_p;
                state_next   = S_CMUL_H;
            end

            S_CMUL_H:
            begin
                mul_x        = WW'(cost_reg[CW-1:WW]);
                mul_y        = f_reg;
                prod_hi_next = mul_p;
                state_next   = S_CACC;
            end

            S_CACC:
            begin
                if (full_prod[3*WW-1:CW] != '0)
                begin
                    cost_next = ecost_pkg::COST_LIMIT;
                    sat_next  = 1'b1;
                end
                else
                begin
                    cost_next = full_prod[CW-1:0];
                end
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    j_next  = j_reg + NW'(1);
                end
                state_next = S_CSEL;
            end

            S_MSEL:
            begin
                if (j_reg == n_reg)
                begin
                    j_next     = '0;
                    state_next = S_ZSEL;
                end
                else if (j_reg[VW-1:0] == root_a_reg || j_reg[VW-1:0] == root_b_reg)
                begin
                    p_next     = '0;
                    state_next = S_MW1;
                end
                else
                begin
                    ram_raddr  = {root_a_reg, j_reg[VW-1:0]};
                    state_next = S_MRA;
                end
            end

            S_MRA:
            begin
                rowa_next  = eff_rdata;
                ram_raddr  = {root_b_reg, j_reg[VW-1:0]};
                state_next = S_MRB;
            end

            S_MRB:
            begin
                mul_x        = rowa_reg;
                mul_y        = eff_rdata;
                prod_lo_next = mul_p;
                state_next   = S_MSAT;
            end

            S_MSAT:
            begin
                if (prod_lo_reg[2*WW-1:WW] != '0)
                begin
                    p_next   = ecost_pkg::WGT_LIMIT;
                    sat_next = 1'b1;
                end
                else
                begin
                    p_next = prod_lo_reg[WW-1:0];
                end
                state_next = S_MW1;
            end

            S_MW1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {root_a_reg, j_reg[VW-1:0]};
                ram_wdata  = p_reg;
                valid_next[{root_a_reg, j_reg[VW-1:0]}] = 1'b1;
                state_next = S_MW2;
            end

            S_MW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {j_reg[VW-1:0], root_a_reg};
                ram_wdata  = p_reg;
                valid_next[{j_reg[VW-1:0], root_a_reg}] = 1'b1;
                j_next     = j_reg + NW'(1);
                state_next = S_MSEL;
            end

            S_ZSEL:
            begin
                if (j_reg == n_reg)
                begin
                    links_next[root_b_reg] = root_a_reg;
                    merged_next = 1'b1;
                    if (sum_reg > ecost_pkg::COST_LIMIT - cost_reg)
                    begin
                        sum_next = ecost_pkg::COST_LIMIT;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_reg + cost_reg;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = {root_b_reg, j_reg[VW-1:0]};
                    ram_wdata  = '0;
                    valid_next[{root_b_reg, j_reg[VW-1:0]}] = 1'b1;
                    state_next = S_ZW2;
                end
            end

            S_ZW2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {j_reg[VW-1:0], root_b_reg};
                ram_wdata  = '0;
                valid_next[{j_reg[VW-1:0], root_b_reg}] = 1'b1;
                j_next     = j_reg + NW'(1);
                state_next = S_ZSEL;
            end

            S_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    out_step_next   = cost_reg;
                    out_total_next  = sum_reg;
                    out_merged_next = merged_reg;
                    out_root_next   = root_reg;
                    out_sat_next    = sat_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= ecost_pkg::VCOUNT_RESET;
            valid_reg     <= '0;
            sum_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < NV; i++)
            begin
                links_reg[i] <= VW'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            rsp_valid_reg <= rsp_valid_next;
            links_reg     <= links_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        va_reg          <= va_next;
        vb_reg          <= vb_next;
        w_reg           <= w_next;
        walk_v_reg      <= walk_v_next;
        walk_k_reg      <= walk_k_next;
        root_a_reg      <= root_a_next;
        root_b_reg      <= root_b_next;
        j_reg           <= j_next;
        ph_reg          <= ph_next;
        cost_reg        <= cost_next;
        sat_reg         <= sat_next;
        merged_reg      <= merged_next;
        root_reg        <= root_next;
        f_reg           <= f_next;
        rowa_reg        <= rowa_next;
        p_reg           <= p_next;
        prod_lo_reg     <= prod_lo_next;
        prod_hi_reg     <= prod_hi_next;
        rd_addr_reg     <= ram_raddr;
        rd_valid_reg    <= valid_reg[ram_raddr];
        out_step_reg    <= out_step_next;
        out_total_reg   <= out_total_next;
        out_merged_reg  <= out_merged_next;
        out_root_reg    <= out_root_next;
        out_sat_reg     <= out_sat_next;
    end

endmodule
